FILE: hdl/key_value_line_tokenizer_top_macros.svh
// assertion macros for the key/value line tokenizer
// no dependencies; included by key_value_line_tokenizer_top only
`ifndef KEY_VALUE_LINE_TOKENIZER_TOP_MACROS_SVH
`define KEY_VALUE_LINE_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define KVLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvlt assertion failed");

// next-cycle implication, checked out of reset
`define KVLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvlt assertion failed");

`endif

FILE: hdl/kvlt_pkg.sv
// shared constants and hash helper for the key/value line tokenizer
// no dependencies; used by key_value_line_tokenizer_top
package kvlt_pkg;

  // field widths
  localparam int unsigned HASH_BITS          = 64;
  localparam int unsigned FIELD_BITS         = 16;
  localparam int unsigned LINE_BITS          = 16;
  localparam int unsigned BYTE_BITS          = 8;
  localparam int unsigned POSITION_BITS_DEF  = 16;
  localparam int unsigned POSITION_BITS_MAX  = 32;

  // fnv-1a 64-bit offset basis
  localparam logic [HASH_BITS-1:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam logic [LINE_BITS-1:0] LINE_MAX   = '1;
  localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

  // character codes
  localparam logic [BYTE_BITS-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_BITS-1:0] CHAR_HASH  = 8'h23;

  // tokens seen on the current line
  localparam logic [1:0] TOK_NONE  = 2'd0;
  localparam logic [1:0] TOK_KEY   = 2'd1;
  localparam logic [1:0] TOK_VALUE = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_ROW       = 2'd0,
    STATUS_NO_VALUE  = 2'd1,
    STATUS_EXTRA     = 2'd2,
    STATUS_EMPTY_END = 2'd3
  } status_e;

  // one fnv-1a round; the prime 2^40 + 0x1b3 is applied as shifts and adds
  function automatic logic [HASH_BITS-1:0] fnv_step(input logic [HASH_BITS-1:0] h,
                                                    input logic [BYTE_BITS-1:0] b);
    logic [HASH_BITS-1:0] x;
    x = h ^ {{(HASH_BITS-BYTE_BITS){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

FILE: hdl/key_value_line_tokenizer_top.sv
// key/value line tokenizer: splits table text into key and value tokens
// depends on kvlt_pkg and key_value_line_tokenizer_top_macros.svh
//
// Usage: one text byte per input transaction on in_valid_i/in_stall_o/
// text_byte_i. A line whose first token (the key) has been seen gives one
// result transaction on out_valid_o/out_stall_i when it ends (newline or
// zero byte): 64-bit FNV-1a key hash, key and value positions and lengths,
// line number and status. A third token gives an extra-token result at once;
// a zero byte on a line without a key gives an end-without-row result.
// After a missing value or an extra token the block stops and drops every
// byte without result until reset.
// A byte accepted is taken into the input register, and its result (if any)
// is then loaded into the result register, which drives out_valid_o; a stall
// on the result channel can hold the byte in the input register in between.
// Throughput: one byte per cycle while the result channel is not stalled, set
// by the state update (hash round, counters and token tracking).
// Stall: a stalled result holds in the result register; the input register
// then holds its byte and in_stall_o is raised until the result is taken.
// Reset (rst_ni low, asynchronous): all registers empty, position 0,
// line 1, hash at the offset basis, stop flag cleared.
`include "key_value_line_tokenizer_top_macros.svh"

module key_value_line_tokenizer_top #(
  parameter int unsigned POSITION_BITS = kvlt_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [kvlt_pkg::BYTE_BITS-1:0]  text_byte_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [kvlt_pkg::HASH_BITS-1:0]  key_digest_o,
  output logic [kvlt_pkg::FIELD_BITS-1:0] key_start_o,
  output logic [kvlt_pkg::FIELD_BITS-1:0] key_length_o,
  output logic [kvlt_pkg::FIELD_BITS-1:0] value_start_o,
  output logic [kvlt_pkg::FIELD_BITS-1:0] value_length_o,
  output logic [kvlt_pkg::LINE_BITS-1:0]  line_number_o,
  output logic [1:0]                      status_o,
  output logic                            is_final_o
);

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;
  localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);

  // saturating position/length increment
  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  // position-width value to a 16-bit output field (zero-extend, then keep low bits)
  function automatic logic [kvlt_pkg::FIELD_BITS-1:0] to_field(
      input logic [POSITION_BITS-1:0] v);
    logic [kvlt_pkg::POSITION_BITS_MAX-1:0] w;
    w = kvlt_pkg::POSITION_BITS_MAX'(v);
    return w[kvlt_pkg::FIELD_BITS-1:0];
  endfunction

  // input register
  logic                           in_valid_q;
  logic [kvlt_pkg::BYTE_BITS-1:0] byte_q;

  // tokenizer state
  logic [POSITION_BITS-1:0]       pos_q, pos_d;
  logic [kvlt_pkg::LINE_BITS-1:0] line_q, line_d;
  logic                           in_comment_q, in_comment_d;
  logic                           after_space_q, after_space_d;
  logic [1:0]                     tok_q, tok_d;
  logic [kvlt_pkg::HASH_BITS-1:0] hash_q, hash_d;
  logic [POSITION_BITS-1:0]       key_start_q, key_start_d;
  logic [POSITION_BITS-1:0]       key_len_q, key_len_d;
  logic [POSITION_BITS-1:0]       val_start_q, val_start_d;
  logic [POSITION_BITS-1:0]       val_len_q, val_len_d;
  logic                           error_stop_q, error_stop_d;

  // result register
  logic                            out_valid_q;
  logic [kvlt_pkg::HASH_BITS-1:0]  res_hash_q;
  logic [kvlt_pkg::FIELD_BITS-1:0] res_key_start_q, res_key_len_q;
  logic [kvlt_pkg::FIELD_BITS-1:0] res_val_start_q, res_val_len_q;
  logic [kvlt_pkg::LINE_BITS-1:0]  res_line_q;
  kvlt_pkg::status_e               res_status_q;
  logic                            res_final_q;

  // handshake and result selection
  logic              advance;
  logic              process;
  logic              res_fire;
  kvlt_pkg::status_e res_status;
  logic              res_final;
  logic              has_key;
  logic              is_end;
  logic              res_empty_end;

  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign has_key    = (tok_q != kvlt_pkg::TOK_NONE);
  assign is_end     = (byte_q == kvlt_pkg::CHAR_NUL) || (byte_q == kvlt_pkg::CHAR_LF);

  // per-byte state update
  always_comb begin
    pos_d         = pos_q;
    line_d        = line_q;
    in_comment_d  = in_comment_q;
    after_space_d = after_space_q;
    tok_d         = tok_q;
    hash_d        = hash_q;
    key_start_d   = key_start_q;
    key_len_d     = key_len_q;
    val_start_d   = val_start_q;
    val_len_d     = val_len_q;
    error_stop_d  = error_stop_q;
    res_fire      = 1'b0;
    res_status    = kvlt_pkg::STATUS_ROW;
    res_final     = 1'b0;

    if (process && !error_stop_q) begin
      pos_d = sat_inc(pos_q);
      if (is_end) begin
        res_final = (byte_q == kvlt_pkg::CHAR_NUL);
        case (tok_q)
          kvlt_pkg::TOK_NONE: begin
            res_fire   = res_final;
            res_status = kvlt_pkg::STATUS_EMPTY_END;
          end
          kvlt_pkg::TOK_KEY: begin
            res_fire     = 1'b1;
            res_status   = kvlt_pkg::STATUS_NO_VALUE;
            error_stop_d = 1'b1;
          end
          default: begin
            res_fire   = 1'b1;
            res_status = kvlt_pkg::STATUS_ROW;
          end
        endcase
        // line cleared
        in_comment_d  = 1'b0;
        after_space_d = 1'b1;
        tok_d         = kvlt_pkg::TOK_NONE;
        hash_d        = kvlt_pkg::FNV_BASIS;
        key_start_d   = POS_ZERO;
        key_len_d     = POS_ZERO;
        val_start_d   = POS_ZERO;
        val_len_d     = POS_ZERO;
        line_d        = (line_q != kvlt_pkg::LINE_MAX) ? line_q + kvlt_pkg::LINE_FIRST : line_q;
        if (res_final) begin
          pos_d  = POS_ZERO;
          line_d = kvlt_pkg::LINE_FIRST;
        end
      end else if (byte_q == kvlt_pkg::CHAR_SPACE || byte_q == kvlt_pkg::CHAR_TAB) begin
        after_space_d = 1'b1;
      end else if (byte_q == kvlt_pkg::CHAR_HASH || !after_space_q) begin
        // comment marker, or a byte continuing the current token
        if (byte_q == kvlt_pkg::CHAR_HASH) begin
          in_comment_d = 1'b1;
        end
        if (!after_space_q) begin
          if (tok_q == kvlt_pkg::TOK_KEY) begin
            hash_d    = kvlt_pkg::fnv_step(hash_q, byte_q);
            key_len_d = sat_inc(key_len_q);
          end else if (tok_q == kvlt_pkg::TOK_VALUE) begin
            val_len_d = sat_inc(val_len_q);
          end
        end
      end else if (!in_comment_q) begin
        // first byte of a new token
        case (tok_q)
          kvlt_pkg::TOK_NONE: begin
            tok_d       = kvlt_pkg::TOK_KEY;
            key_start_d = pos_q;
            key_len_d   = POS_ONE;
            hash_d      = kvlt_pkg::fnv_step(kvlt_pkg::FNV_BASIS, byte_q);
          end
          kvlt_pkg::TOK_KEY: begin
            tok_d       = kvlt_pkg::TOK_VALUE;
            val_start_d = pos_q;
            val_len_d   = POS_ONE;
          end
          default: begin
            res_fire     = 1'b1;
            res_status   = kvlt_pkg::STATUS_EXTRA;
            error_stop_d = 1'b1;
          end
        endcase
        after_space_d = 1'b0;
      end
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= text_byte_i;
    end
  end

  // tokenizer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= POS_ZERO;
      line_q        <= kvlt_pkg::LINE_FIRST;
      in_comment_q  <= 1'b0;
      after_space_q <= 1'b1;
      tok_q         <= kvlt_pkg::TOK_NONE;
      hash_q        <= kvlt_pkg::FNV_BASIS;
      key_start_q   <= POS_ZERO;
      key_len_q     <= POS_ZERO;
      val_start_q   <= POS_ZERO;
      val_len_q     <= POS_ZERO;
      error_stop_q  <= 1'b0;
    end else begin
      pos_q         <= pos_d;
      line_q        <= line_d;
      in_comment_q  <= in_comment_d;
      after_space_q <= after_space_d;
      tok_q         <= tok_d;
      hash_q        <= hash_d;
      key_start_q   <= key_start_d;
      key_len_q     <= key_len_d;
      val_start_q   <= val_start_d;
      val_len_q     <= val_len_d;
      error_stop_q  <= error_stop_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_fire;
    end
  end

  // result register payload, built from the state before this byte
  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      res_hash_q      <= has_key ? hash_q : '0;
      res_key_start_q <= has_key ? to_field(key_start_q) : '0;
      res_key_len_q   <= has_key ? to_field(key_len_q) : '0;
      res_val_start_q <= to_field(val_start_q);
      res_val_len_q   <= to_field(val_len_q);
      res_line_q      <= line_q;
      res_status_q    <= res_status;
      res_final_q     <= res_final;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_digest_o   = res_hash_q;
  assign key_start_o    = res_key_start_q;
  assign key_length_o   = res_key_len_q;
  assign value_start_o  = res_val_start_q;
  assign value_length_o = res_val_len_q;
  assign line_number_o  = res_line_q;
  assign status_o       = res_status_q;
  assign is_final_o     = res_final_q;

  assign res_empty_end = (res_status_q == kvlt_pkg::STATUS_EMPTY_END);

  // assertions
  `KVLT_ASSERT_NEXT(a_stop_sticky, clk_i, rst_ni, error_stop_q, error_stop_q)
  `KVLT_ASSERT_NEXT(a_stopped_quiet, clk_i, rst_ni, error_stop_q && !out_valid_q, !out_valid_q)
  `KVLT_ASSERT_NOW(a_empty_end_is_final, clk_i, rst_ni, out_valid_q && res_empty_end, res_final_q)
  `KVLT_ASSERT_NOW(a_line_nonzero, clk_i, rst_ni, 1'b1, line_q != '0)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for key_value_line_tokenizer_top: text bytes in, line results out
// depends on kvlt_pkg and the tokenizer rtl; carries its own line predictor
module tb_top;

  localparam int unsigned POS_W = kvlt_pkg::POSITION_BITS_DEF;
  localparam logic [kvlt_pkg::HASH_BITS-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

  // one result transaction, field by field
  typedef struct packed {
    logic [kvlt_pkg::HASH_BITS-1:0]  key_digest;
    logic [kvlt_pkg::FIELD_BITS-1:0] key_start;
    logic [kvlt_pkg::FIELD_BITS-1:0] key_length;
    logic [kvlt_pkg::FIELD_BITS-1:0] value_start;
    logic [kvlt_pkg::FIELD_BITS-1:0] value_length;
    logic [kvlt_pkg::LINE_BITS-1:0]  line_number;
    kvlt_pkg::status_e               status;
    logic                            is_final;
  } line_result_t;

  // opening script row: text byte, plus a hand-written result where one is given
  typedef struct packed {
    logic [kvlt_pkg::BYTE_BITS-1:0] text;
    bit                             typed;
    line_result_t                   fixed;
  } script_row_t;

  localparam line_result_t NO_LINE = '0;
  localparam line_result_t FIRST_EMPTY_END = '{
    key_digest: '0, key_start: '0, key_length: '0, value_start: '0, value_length: '0,
    line_number: kvlt_pkg::LINE_FIRST, status: kvlt_pkg::STATUS_EMPTY_END, is_final: 1'b1};

  logic                            clk_i;
  logic                            rst_ni    = 1'b0;
  logic                            in_valid  = 1'b0;
  logic [kvlt_pkg::BYTE_BITS-1:0]  text_byte = '0;
  logic                            out_stall = 1'b0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  logic [kvlt_pkg::HASH_BITS-1:0]  key_digest_o;
  logic [kvlt_pkg::FIELD_BITS-1:0] key_start_o;
  logic [kvlt_pkg::FIELD_BITS-1:0] key_length_o;
  logic [kvlt_pkg::FIELD_BITS-1:0] value_start_o;
  logic [kvlt_pkg::FIELD_BITS-1:0] value_length_o;
  logic [kvlt_pkg::LINE_BITS-1:0]  line_number_o;
  logic [1:0]                      status_o;
  logic                            is_final_o;

  // predictor state
  logic [POS_W-1:0]               scan_pos    = '0;
  logic [kvlt_pkg::LINE_BITS-1:0] line_no     = kvlt_pkg::LINE_FIRST;
  bit                             in_remark   = 1'b0;
  bit                             after_blank = 1'b1;
  logic [1:0]                     token_count = kvlt_pkg::TOK_NONE;
  logic [kvlt_pkg::HASH_BITS-1:0] digest_acc  = kvlt_pkg::FNV_BASIS;
  logic [POS_W-1:0]               key_at      = '0;
  logic [POS_W-1:0]               key_len     = '0;
  logic [POS_W-1:0]               value_at    = '0;
  logic [POS_W-1:0]               value_len   = '0;
  bit                             halted      = 1'b0;

  line_result_t expected_lines[$];
  int           mismatch_count = 0;
  int           fed_bytes      = 0;
  int           feed_level     = 1;
  int           stall_level    = 1;

  script_row_t opening_script [25] = '{
    '{kvlt_pkg::CHAR_NUL,   1'b1, FIRST_EMPTY_END},  // empty end straight after reset
    '{kvlt_pkg::CHAR_LF,    1'b0, NO_LINE},          // empty line
    '{kvlt_pkg::CHAR_TAB,   1'b0, NO_LINE},
    '{8'hFF,                1'b0, NO_LINE},          // key with top byte value
    '{8'h01,                1'b0, NO_LINE},
    '{kvlt_pkg::CHAR_SPACE, 1'b0, NO_LINE},
    '{8'h80,                1'b0, NO_LINE},          // value
    '{kvlt_pkg::CHAR_HASH,  1'b0, NO_LINE},          // '#' runs on inside the value
    '{8'h7F,                1'b0, NO_LINE},
    '{kvlt_pkg::CHAR_LF,    1'b0, NO_LINE},          // row
    '{kvlt_pkg::CHAR_HASH,  1'b0, NO_LINE},          // comment-only line
    '{8'h78,                1'b0, NO_LINE},
    '{kvlt_pkg::CHAR_LF,    1'b0, NO_LINE},
    '{8'h71,                1'b0, NO_LINE},
    '{kvlt_pkg::CHAR_SPACE, 1'b0, NO_LINE},
    '{8'h77,                1'b0, NO_LINE},
    '{kvlt_pkg::CHAR_SPACE, 1'b0, NO_LINE},
    '{kvlt_pkg::CHAR_HASH,  1'b0, NO_LINE},          // comment after the value
    '{8'h7A,                1'b0, NO_LINE},          // no third token inside a comment
    '{kvlt_pkg::CHAR_NUL,   1'b0, NO_LINE},          // row closing the table
    '{kvlt_pkg::CHAR_SPACE, 1'b0, NO_LINE},
    '{8'h61,                1'b0, NO_LINE},
    '{kvlt_pkg::CHAR_TAB,   1'b0, NO_LINE},
    '{8'h62,                1'b0, NO_LINE},
    '{kvlt_pkg::CHAR_LF,    1'b0, NO_LINE}
  };

  key_value_line_tokenizer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .key_digest_o   (key_digest_o),
    .key_start_o    (key_start_o),
    .key_length_o   (key_length_o),
    .value_start_o  (value_start_o),
    .value_length_o (value_length_o),
    .line_number_o  (line_number_o),
    .status_o       (status_o),
    .is_final_o     (is_final_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] v);
    return (v == '1) ? v : v + POS_W'(1);
  endfunction

  function automatic void clear_line();
    in_remark   = 1'b0;
    after_blank = 1'b1;
    token_count = kvlt_pkg::TOK_NONE;
    digest_acc  = kvlt_pkg::FNV_BASIS;
    key_at      = '0;
    key_len     = '0;
    value_at    = '0;
    value_len   = '0;
  endfunction

  // key bytes feed the hash, value bytes only the length
  function automatic void grow_token(input logic [kvlt_pkg::BYTE_BITS-1:0] b);
    if (token_count == kvlt_pkg::TOK_KEY) begin
      digest_acc = (digest_acc ^ {{(kvlt_pkg::HASH_BITS-kvlt_pkg::BYTE_BITS){1'b0}}, b})
                   * FNV_PRIME;
      key_len    = bump(key_len);
    end else if (token_count == kvlt_pkg::TOK_VALUE) begin
      value_len = bump(value_len);
    end
  endfunction

  function automatic line_result_t make_result(input kvlt_pkg::status_e st, input bit fin);
    line_result_t r = '0;
    if (token_count != kvlt_pkg::TOK_NONE) begin
      r.key_digest = digest_acc;
      r.key_start  = kvlt_pkg::FIELD_BITS'(key_at);
      r.key_length = kvlt_pkg::FIELD_BITS'(key_len);
    end
    r.value_start  = kvlt_pkg::FIELD_BITS'(value_at);
    r.value_length = kvlt_pkg::FIELD_BITS'(value_len);
    r.line_number  = line_no;
    r.status       = st;
    r.is_final     = fin;
    return r;
  endfunction

  // advance the line state by one byte; returns 1 when a result is due
  function automatic bit tokenize_byte(input logic [kvlt_pkg::BYTE_BITS-1:0] b,
                                       output line_result_t r);
    logic [POS_W-1:0] here;
    bit               fin;
    bit               produced;
    r        = '0;
    produced = 1'b0;
    if (halted) return 1'b0;
    here     = scan_pos;
    scan_pos = bump(scan_pos);
    if (b == kvlt_pkg::CHAR_NUL || b == kvlt_pkg::CHAR_LF) begin
      fin = (b == kvlt_pkg::CHAR_NUL);
      if (token_count == kvlt_pkg::TOK_NONE) begin
        if (fin) begin
          r        = make_result(kvlt_pkg::STATUS_EMPTY_END, 1'b1);
          produced = 1'b1;
        end
      end else if (token_count == kvlt_pkg::TOK_KEY) begin
        r        = make_result(kvlt_pkg::STATUS_NO_VALUE, fin);
        produced = 1'b1;
        halted   = 1'b1;
      end else begin
        r        = make_result(kvlt_pkg::STATUS_ROW, fin);
        produced = 1'b1;
      end
      clear_line();
      if (line_no != kvlt_pkg::LINE_MAX) line_no = line_no + kvlt_pkg::LINE_FIRST;
      if (fin) begin
        scan_pos = '0;
        line_no  = kvlt_pkg::LINE_FIRST;
      end
    end else if (b == kvlt_pkg::CHAR_SPACE || b == kvlt_pkg::CHAR_TAB) begin
      after_blank = 1'b1;
    end else if (b == kvlt_pkg::CHAR_HASH) begin
      in_remark = 1'b1;
      if (!after_blank) grow_token(b);
    end else if (!after_blank) begin
      grow_token(b);
    end else if (!in_remark) begin
      // first byte of a new token
      if (token_count == kvlt_pkg::TOK_NONE) begin
        token_count = kvlt_pkg::TOK_KEY;
        key_at      = here;
        key_len     = '0;
        digest_acc  = kvlt_pkg::FNV_BASIS;
        grow_token(b);
      end else if (token_count == kvlt_pkg::TOK_KEY) begin
        token_count = kvlt_pkg::TOK_VALUE;
        value_at    = here;
        value_len   = '0;
        grow_token(b);
      end else begin
        r        = make_result(kvlt_pkg::STATUS_EXTRA, 1'b0);
        produced = 1'b1;
        halted   = 1'b1;
      end
      after_blank = 1'b0;
    end
    return produced;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_line_result();
    line_result_t want;
    if (expected_lines.size() == 0) begin
      report_mismatch("result transaction with nothing expected", key_digest_o, '0);
      return;
    end
    want = expected_lines.pop_front();
    if (key_digest_o !== want.key_digest)
      report_mismatch("key_digest", key_digest_o, want.key_digest);
    if (key_start_o !== want.key_start)
      report_mismatch("key_start", 64'(key_start_o), 64'(want.key_start));
    if (key_length_o !== want.key_length)
      report_mismatch("key_length", 64'(key_length_o), 64'(want.key_length));
    if (value_start_o !== want.value_start)
      report_mismatch("value_start", 64'(value_start_o), 64'(want.value_start));
    if (value_length_o !== want.value_length)
      report_mismatch("value_length", 64'(value_length_o), 64'(want.value_length));
    if (line_number_o !== want.line_number)
      report_mismatch("line_number", 64'(line_number_o), 64'(want.line_number));
    if (status_o !== want.status)
      report_mismatch("status", 64'(status_o), 64'(want.status));
    if (is_final_o !== want.is_final)
      report_mismatch("is_final", 64'(is_final_o), 64'(want.is_final));
  endtask

  // result side: accepted when valid and not stalled at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall) check_line_result();
  end

  // ---------------------------------------------------------------- idling

  // no gap at level 0; above it, no gap or a short one, and now and then a long one
  function automatic int pick_gap(input int level);
    int roll;
    roll = $urandom_range(0, 99);
    if (level == 0) return 0;
    if (roll < 100 - 30 * level) return 0;
    if (roll < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random stall on the result channel
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      hold = pick_gap(stall_level);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one input transaction, predicted once accepted
  task automatic send_byte(input logic [kvlt_pkg::BYTE_BITS-1:0] b, input bit typed = 1'b0,
                           input line_result_t fixed = '0);
    int           gap;
    bit           produced;
    line_result_t got;
    gap = pick_gap(feed_level);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    produced = tokenize_byte(b, got);
    if (typed) expected_lines.push_back(fixed);
    else if (produced) expected_lines.push_back(got);
    fed_bytes++;
  endtask

  // any byte that is not a separator, '#' only where allowed
  function automatic logic [kvlt_pkg::BYTE_BITS-1:0] token_byte(input bit allow_hash);
    logic [kvlt_pkg::BYTE_BITS-1:0] b;
    do b = kvlt_pkg::BYTE_BITS'($urandom_range(1, 255));
    while (b == kvlt_pkg::CHAR_TAB || b == kvlt_pkg::CHAR_LF || b == kvlt_pkg::CHAR_SPACE ||
           (!allow_hash && b == kvlt_pkg::CHAR_HASH));
    return b;
  endfunction

  task automatic send_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi))
      send_byte($urandom_range(0, 1) ? kvlt_pkg::CHAR_SPACE : kvlt_pkg::CHAR_TAB);
  endtask

  task automatic send_token(input bit allow_hash);
    int len;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
    send_byte(token_byte(1'b0));
    repeat (len - 1) send_byte(token_byte(allow_hash));
  endtask

  // comment: anything up to the line end
  task automatic send_remark();
    logic [kvlt_pkg::BYTE_BITS-1:0] b;
    send_blanks(0, 2);
    send_byte(kvlt_pkg::CHAR_HASH);
    repeat ($urandom_range(0, 6)) begin
      do b = kvlt_pkg::BYTE_BITS'($urandom_range(1, 255)); while (b == kvlt_pkg::CHAR_LF);
      send_byte(b);
    end
  endtask

  // well-formed line: row, blank or comment line, or an empty table end
  task automatic send_random_line();
    int kind;
    kind = $urandom_range(0, 99);
    send_blanks(0, 2);
    if (kind < 70) begin
      send_token(1'b0);
      send_blanks(1, 3);
      send_token(1'b1);
      if ($urandom_range(0, 1)) send_remark();
      else send_blanks(0, 2);
      send_byte(($urandom_range(0, 9) == 0) ? kvlt_pkg::CHAR_NUL : kvlt_pkg::CHAR_LF);
    end else begin
      if ($urandom_range(0, 1)) send_remark();
      send_byte((kind < 88) ? kvlt_pkg::CHAR_LF : kvlt_pkg::CHAR_NUL);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int  drain;
    bit  paused;
    paused = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening script
    foreach (opening_script[i])
      send_byte(opening_script[i].text, opening_script[i].typed, opening_script[i].fixed);

    // random lines, with one full drain halfway through
    fed_bytes = 0;
    while (fed_bytes < 800) begin
      if ($urandom_range(0, 9) == 0) begin
        feed_level  = $urandom_range(0, 2);
        stall_level = $urandom_range(0, 2);
      end
      if (!paused && fed_bytes >= 400) begin
        in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
        paused = 1'b1;
      end
      send_random_line();
    end

    // one sticky error to close the run, then bytes the stopped block must drop
    feed_level  = 1;
    stall_level = 1;
    send_blanks(0, 1);
    send_token(1'b0);
    if ($urandom_range(0, 1)) begin
      send_blanks(1, 2);
      send_token(1'b0);
      send_blanks(1, 2);
      send_byte(token_byte(1'b0));
    end else begin
      send_byte($urandom_range(0, 1) ? kvlt_pkg::CHAR_LF : kvlt_pkg::CHAR_NUL);
    end
    send_byte(8'h61);
    send_byte(kvlt_pkg::CHAR_SPACE);
    send_byte(8'h62);
    send_byte(kvlt_pkg::CHAR_LF);
    send_byte(kvlt_pkg::CHAR_NUL);
    in_valid <= 1'b0;

    // wait for outstanding results, then a few cycles for stragglers
    drain = 0;
    while (expected_lines.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    if (expected_lines.size() != 0)
      report_mismatch("results never delivered", 64'(expected_lines.size()), '0);
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/kvlt_pkg.sv
hdl/key_value_line_tokenizer_top.sv
bench/tb_top.sv
